[rtl/tts_pkg.sv]
// Shared types, constants and controller/datapath command structs for the timer table.
package tts_pkg;

	// Field widths of the input and result words.
	localparam int W_ACTION = 3;
	localparam int W_TIME   = 32;
	localparam int W_SLOT   = 4;
	localparam int W_STATUS = 2;

	// Default table depth.
	localparam int NUM_SLOTS_DEF = 16;

	// Action codes carried by an input word.
	localparam logic [W_ACTION-1:0] ACT_PROCESS    = 3'd0;
	localparam logic [W_ACTION-1:0] ACT_CREATE     = 3'd1;
	localparam logic [W_ACTION-1:0] ACT_KILL       = 3'd2;
	localparam logic [W_ACTION-1:0] ACT_KILL_LATER = 3'd3;
	localparam logic [W_ACTION-1:0] ACT_RESTART    = 3'd4;

	// Result status codes.
	localparam logic [W_STATUS-1:0] RS_OK    = 2'd0;
	localparam logic [W_STATUS-1:0] RS_ERR   = 2'd1;
	localparam logic [W_STATUS-1:0] RS_EVENT = 2'd2;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SINGLE,
		S_CREATE,
		S_SCAN,
		S_FIN
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                ready;       // take an input word
		logic                adv;         // step the slot index, wrapping to zero
		logic                emit;        // load the result register
		logic [W_STATUS-1:0] emit_status;
		logic                emit_idx;    // result slot is the scan index, else zero
		logic                emit_last;
		logic                cr_write;    // create a timer at the scan index
		logic                kill;        // free the addressed slot
		logic                kill_later;  // clear the periodic flag of the addressed slot
		logic                rs_write;    // restart the addressed slot
		logic                sc_restart;  // restart the scanned slot
		logic                sc_free;     // free the scanned slot
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic                req_valid;
		logic [W_ACTION-1:0] action;
		logic                in_use;       // addressed slot exists and is active
		logic                cur_active;   // scanned slot is active
		logic                cur_expired;
		logic                cur_notify;
		logic                cur_periodic;
		logic                last_idx;     // scan index is at the top slot
		logic                out_free;     // result register can take a word
	} dp_status_t;

endpackage

[rtl/tts_in_if.sv]
// Handshake channel that carries timer request words.
interface tts_in_if;
	logic                          valid;
	logic                          ready;
	logic [tts_pkg::W_ACTION-1:0]  action;
	logic [tts_pkg::W_TIME-1:0]    now_ms;
	logic [tts_pkg::W_SLOT-1:0]    slot;
	logic [tts_pkg::W_TIME-1:0]    timeout_ms;
	logic                          periodic;
	logic                          notify;

	modport source (
		output valid, action, now_ms, slot, timeout_ms, periodic, notify,
		input  ready
	);
	modport sink (
		input  valid, action, now_ms, slot, timeout_ms, periodic, notify,
		output ready
	);
endinterface

[rtl/tts_out_if.sv]
// Handshake channel that carries timer result words.
interface tts_out_if;
	logic                          valid;
	logic                          ready;
	logic [tts_pkg::W_STATUS-1:0]  status;
	logic [tts_pkg::W_SLOT-1:0]    slot_out;
	logic                          last;

	modport source (
		output valid, status, slot_out, last,
		input  ready
	);
	modport sink (
		input  valid, status, slot_out, last,
		output ready
	);
endinterface

[rtl/tts_dpath.sv]
// Timer table datapath: slot flags, start and timeout memories, scan index and result register.
module tts_dpath #(
	parameter int NUM_SLOTS = tts_pkg::NUM_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tts_in_if.sink               req,
	tts_out_if.source            rsp,
	input  tts_pkg::ctl_cmd_t    cmd,
	output tts_pkg::dp_status_t  sts
);

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	// Latched request word.
	logic [tts_pkg::W_ACTION-1:0] act_q;
	logic [tts_pkg::W_TIME-1:0]   now_q;
	logic [tts_pkg::W_SLOT-1:0]   slot_q;
	logic [tts_pkg::W_TIME-1:0]   tmo_q;
	logic                         per_q;
	logic                         ntf_q;

	// Slot flags, cleared by reset.
	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] periodic_q;
	logic [NUM_SLOTS-1:0] notify_q;

	// Start time and timeout memories.
	logic [tts_pkg::W_TIME-1:0] start_mem [NUM_SLOTS];
	logic [tts_pkg::W_TIME-1:0] tmo_mem   [NUM_SLOTS];
	logic [tts_pkg::W_TIME-1:0] start_rd_q;
	logic [tts_pkg::W_TIME-1:0] tmo_rd_q;

	// Scan index and result register.
	logic [IW-1:0]                idx_q;
	logic [IW-1:0]                idx_d;
	logic                         out_valid_q;
	logic [tts_pkg::W_STATUS-1:0] out_status_q;
	logic [tts_pkg::W_SLOT-1:0]   out_slot_q;
	logic                         out_last_q;

	logic                         accept;
	logic [IW-1:0]                slot_idx;
	logic                         slot_in_range;
	logic [tts_pkg::W_TIME-1:0]   elapsed;
	logic                         last_idx;
	logic                         wr_start;
	logic [IW-1:0]                wr_start_addr;

	assign accept        = cmd.ready && req.valid;
	assign req.ready     = cmd.ready;
	assign slot_idx      = IW'(slot_q);
	assign slot_in_range = 32'(slot_q) < NUM_SLOTS;
	assign last_idx      = idx_q == IW'(NUM_SLOTS - 1);
	assign elapsed       = now_q - start_rd_q;

	// Capture the request word on acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= req.action;
			now_q  <= req.now_ms;
			slot_q <= req.slot;
			tmo_q  <= req.timeout_ms;
			per_q  <= req.periodic;
			ntf_q  <= req.notify;
		end
	end

	// Next scan index; it also addresses the memory reads, so the registered read data match the scan index.
	always_comb begin
		idx_d = idx_q;
		if (accept) begin
			idx_d = '0;
		end else if (cmd.adv) begin
			idx_d = last_idx ? '0 : idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			idx_q <= idx_d;
		end
	end

	// Flag updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			periodic_q <= '0;
			notify_q   <= '0;
		end else begin
			if (cmd.cr_write) begin
				active_q[idx_q]   <= 1'b1;
				periodic_q[idx_q] <= per_q;
				notify_q[idx_q]   <= ntf_q;
			end
			if (cmd.sc_free) begin
				active_q[idx_q] <= 1'b0;
			end
			if (cmd.kill) begin
				active_q[slot_idx] <= 1'b0;
			end
			if (cmd.kill_later) begin
				periodic_q[slot_idx] <= 1'b0;
			end
		end
	end

	// Start memory write port is shared by create, restart and scan restart.
	assign wr_start      = cmd.cr_write || cmd.sc_restart || cmd.rs_write;
	assign wr_start_addr = cmd.rs_write ? slot_idx : idx_q;

	always_ff @(posedge clk) begin
		if (wr_start) begin
			start_mem[wr_start_addr] <= now_q;
		end
		start_rd_q <= start_mem[idx_d];
	end

	always_ff @(posedge clk) begin
		if (cmd.cr_write) begin
			tmo_mem[idx_q] <= tmo_q;
		end
		tmo_rd_q <= tmo_mem[idx_d];
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= cmd.emit_status;
			out_slot_q   <= cmd.emit_idx ? tts_pkg::W_SLOT'(idx_q) : '0;
			out_last_q   <= cmd.emit_last;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.slot_out = out_slot_q;
	assign rsp.last     = out_last_q;

	// Status toward the controller.
	always_comb begin
		sts              = '0;
		sts.req_valid    = req.valid;
		sts.action       = act_q;
		sts.in_use       = slot_in_range && active_q[slot_idx];
		sts.cur_active   = active_q[idx_q];
		sts.cur_expired  = elapsed >= tmo_rd_q;
		sts.cur_notify   = notify_q[idx_q];
		sts.cur_periodic = periodic_q[idx_q];
		sts.last_idx     = last_idx;
		sts.out_free     = !out_valid_q || rsp.ready;
	end

	// A freshly created timer is active on the next cycle.
	a_create_sets_active: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cr_write |=> active_q[$past(idx_q)])
		else $error("created slot is not active");

	// A scan free never coincides with a scan restart.
	a_free_xor_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sc_free |-> !cmd.sc_restart)
		else $error("scanned slot both freed and restarted");

endmodule

[rtl/tts_ctrl.sv]
// Timer table controller: sequences single commands, create search and the expiry scan.
module tts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tts_pkg::dp_status_t  sts,
	output tts_pkg::ctl_cmd_t    cmd
);

	tts_pkg::ctl_state_t state_q;
	tts_pkg::ctl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			tts_pkg::S_IDLE: begin
				cmd.ready = 1'b1;
				if (sts.req_valid) begin
					state_d = tts_pkg::S_DECODE;
				end
			end
			tts_pkg::S_DECODE: begin
				case (sts.action)
					tts_pkg::ACT_PROCESS: state_d = tts_pkg::S_SCAN;
					tts_pkg::ACT_CREATE:  state_d = tts_pkg::S_CREATE;
					default:              state_d = tts_pkg::S_SINGLE;
				endcase
			end
			tts_pkg::S_SINGLE: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = tts_pkg::RS_ERR;
					if (sts.in_use) begin
						case (sts.action)
							tts_pkg::ACT_KILL: begin
								cmd.kill        = 1'b1;
								cmd.emit_status = tts_pkg::RS_OK;
							end
							tts_pkg::ACT_KILL_LATER: begin
								cmd.kill_later  = 1'b1;
								cmd.emit_status = tts_pkg::RS_OK;
							end
							tts_pkg::ACT_RESTART: begin
								cmd.rs_write    = 1'b1;
								cmd.emit_status = tts_pkg::RS_OK;
							end
							default: begin
								cmd.emit_status = tts_pkg::RS_ERR;
							end
						endcase
					end
					state_d = tts_pkg::S_IDLE;
				end
			end
			tts_pkg::S_CREATE: begin
				// Walk the slots upward until a free one turns up, or report an error at the top slot.
				if (!sts.cur_active) begin
					if (sts.out_free) begin
						cmd.cr_write    = 1'b1;
						cmd.emit        = 1'b1;
						cmd.emit_status = tts_pkg::RS_OK;
						cmd.emit_idx    = 1'b1;
						cmd.emit_last   = 1'b1;
						state_d         = tts_pkg::S_IDLE;
					end
				end else if (sts.last_idx) begin
					if (sts.out_free) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = tts_pkg::RS_ERR;
						cmd.emit_last   = 1'b1;
						state_d         = tts_pkg::S_IDLE;
					end
				end else begin
					cmd.adv = 1'b1;
				end
			end
			tts_pkg::S_SCAN: begin
				// One slot per cycle; an event waits for room in the result register.
				if (sts.cur_active && sts.cur_expired) begin
					if (!sts.cur_notify || sts.out_free) begin
						cmd.emit        = sts.cur_notify;
						cmd.emit_status = tts_pkg::RS_EVENT;
						cmd.emit_idx    = 1'b1;
						cmd.sc_restart  = sts.cur_periodic;
						cmd.sc_free     = !sts.cur_periodic;
						cmd.adv         = 1'b1;
						if (sts.last_idx) begin
							state_d = tts_pkg::S_FIN;
						end
					end
				end else begin
					cmd.adv = 1'b1;
					if (sts.last_idx) begin
						state_d = tts_pkg::S_FIN;
					end
				end
			end
			tts_pkg::S_FIN: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = tts_pkg::RS_OK;
					cmd.emit_last   = 1'b1;
					state_d         = tts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tts_pkg::S_IDLE;
			end
		endcase
	end

	// A result word is only loaded when the result register has room.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result word loaded into a full register");

	// An accepted word is always decoded on the next cycle.
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ready && sts.req_valid) |=> state_q == tts_pkg::S_DECODE)
		else $error("accepted word not decoded");

	// The closing word of a scan returns the controller to idle.
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tts_pkg::S_FIN && cmd.emit) |=> state_q == tts_pkg::S_IDLE)
		else $error("scan did not finish");

	// Every word marked last ends the work on the current request.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_last) |=> state_q == tts_pkg::S_IDLE)
		else $error("last word emitted mid-request");

endmodule

[rtl/timer_table_expiry_scan.sv]
// Each request passes through the decode state and then a single-command, create or scan state;
// create walks the slots one per cycle until it finds a free slot or reaches the top slot, and
// process scans every slot one per cycle, with its events ahead of its closing word. The next
// word is accepted once the controller is back in idle, as the last result word is loaded;
// a stalled result register delays both that result word and the next acceptance.
// Reset (arst_n, asynchronous, active low) frees every slot and empties the result register.
module timer_table_expiry_scan #(
	parameter int NUM_SLOTS = tts_pkg::NUM_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tts_in_if.sink     req,
	tts_out_if.source  rsp
);

	tts_pkg::ctl_cmd_t   cmd;
	tts_pkg::dp_status_t sts;

	// Controller.
	tts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Datapath.
	tts_dpath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

[tb/tb_timer_table_expiry_scan.sv]
// Self-checking testbench for the timer table: directed and random requests against a shadow table.
module tb_timer_table_expiry_scan;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = tts_pkg::NUM_SLOTS_DEF;
	localparam int RANDOM_WORDS = 405;
	localparam int HOLD_CYCLES = 250;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	// Action codes that the block does not define; they must be rejected.
	localparam logic [tts_pkg::W_ACTION-1:0] ACT_UNUSED_FIRST = 3'd5;
	localparam logic [tts_pkg::W_ACTION-1:0] ACT_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [tts_pkg::W_ACTION-1:0] action;
		logic [tts_pkg::W_TIME-1:0]   now_ms;
		logic [tts_pkg::W_SLOT-1:0]   slot;
		logic [tts_pkg::W_TIME-1:0]   timeout_ms;
		logic                         periodic;
		logic                         notify;
	} timer_req_t;

	typedef struct packed {
		logic [tts_pkg::W_STATUS-1:0] status;
		logic [tts_pkg::W_SLOT-1:0]   slot_out;
		logic                         last;
	} timer_rsp_t;

	// Shadow copy of the timer table plus the queue of result words still owed.
	class timer_table_shadow;
		bit                         active [TABLE_DEPTH];
		bit                         periodic [TABLE_DEPTH];
		bit                         notify [TABLE_DEPTH];
		logic [tts_pkg::W_TIME-1:0] start_ms [TABLE_DEPTH];
		logic [tts_pkg::W_TIME-1:0] timeout_ms [TABLE_DEPTH];
		timer_rsp_t                 owed_results [$];
		int unsigned                faults;
		int unsigned                requests_taken;
		int unsigned                results_seen;
		int unsigned                expiries_seen;
		int unsigned                errors_seen;
		int unsigned                full_rejects;

		function void push_result(logic [tts_pkg::W_STATUS-1:0] status, int slot, bit last);
			owed_results.push_back('{status: status, slot_out: slot[tts_pkg::W_SLOT-1:0],
				last: last});
		endfunction

		// Apply one accepted request to the shadow table and queue its result words.
		function void take_request(timer_req_t r);
			bit                         in_use;
			bit                         found;
			logic [tts_pkg::W_TIME-1:0] elapsed;
			int                         i;
			requests_taken++;
			in_use = (int'(r.slot) < TABLE_DEPTH) && active[r.slot];
			case (r.action)
				tts_pkg::ACT_PROCESS: begin
					for (i = 0; i < TABLE_DEPTH; i++) begin
						if (active[i]) begin
							elapsed = r.now_ms - start_ms[i];
							if (elapsed >= timeout_ms[i]) begin
								if (notify[i])
									push_result(tts_pkg::RS_EVENT, i, 1'b0);
								if (periodic[i])
									start_ms[i] = r.now_ms;
								else
									active[i] = 1'b0;
							end
						end
					end
					push_result(tts_pkg::RS_OK, 0, 1'b1);
				end
				tts_pkg::ACT_CREATE: begin
					found = 1'b0;
					for (i = 0; i < TABLE_DEPTH && !found; i++) begin
						if (!active[i]) begin
							active[i] = 1'b1;
							periodic[i] = r.periodic;
							notify[i] = r.notify;
							start_ms[i] = r.now_ms;
							timeout_ms[i] = r.timeout_ms;
							push_result(tts_pkg::RS_OK, i, 1'b1);
							found = 1'b1;
						end
					end
					if (!found) begin
						full_rejects++;
						push_result(tts_pkg::RS_ERR, 0, 1'b1);
					end
				end
				tts_pkg::ACT_KILL: begin
					if (in_use)
						active[r.slot] = 1'b0;
					push_result(in_use ? tts_pkg::RS_OK : tts_pkg::RS_ERR, 0, 1'b1);
				end
				tts_pkg::ACT_KILL_LATER: begin
					if (in_use)
						periodic[r.slot] = 1'b0;
					push_result(in_use ? tts_pkg::RS_OK : tts_pkg::RS_ERR, 0, 1'b1);
				end
				tts_pkg::ACT_RESTART: begin
					if (in_use)
						start_ms[r.slot] = r.now_ms;
					push_result(in_use ? tts_pkg::RS_OK : tts_pkg::RS_ERR, 0, 1'b1);
				end
				default: begin
					push_result(tts_pkg::RS_ERR, 0, 1'b1);
				end
			endcase
		endfunction

		// Compare one accepted result word with the oldest one owed.
		function void check_result(timer_rsp_t got);
			timer_rsp_t want;
			results_seen++;
			if (got.status == tts_pkg::RS_EVENT)
				expiries_seen++;
			if (got.status == tts_pkg::RS_ERR)
				errors_seen++;
			if (owed_results.size() == 0) begin
				faults++;
				if (faults <= MAX_REPORTS)
					$display("unexpected result word: status %0d slot %0d last %0d",
						got.status, got.slot_out, got.last);
				return;
			end
			want = owed_results.pop_front();
			if (got.status != want.status || got.slot_out != want.slot_out ||
					got.last != want.last) begin
				faults++;
				if (faults <= MAX_REPORTS)
					$display({"result mismatch: expected status %0d slot %0d last %0d, ",
						"got status %0d slot %0d last %0d"},
						want.status, want.slot_out, want.last,
						got.status, got.slot_out, got.last);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tts_in_if  req_if ();
	tts_out_if rsp_if ();

	timer_table_shadow shadow = new();

	int unsigned                quiet_cycles = 0;
	bit                         send_gaps = 1'b0;
	bit                         recv_stalls = 1'b0;
	bit                         hold_request = 1'b0;
	int unsigned                holds_done = 0;
	logic [tts_pkg::W_TIME-1:0] clock_ms = '0;

	timer_table_expiry_scan #(
		.NUM_SLOTS(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle lengths: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Usually aim at a live slot so that kill, kill later and restart do real work.
	function automatic logic [tts_pkg::W_SLOT-1:0] pick_slot();
		int live [$];
		int i;
		for (i = 0; i < TABLE_DEPTH; i++)
			if (shadow.active[i])
				live.push_back(i);
		if (live.size() != 0 && $urandom_range(0, 3) != 0)
			return tts_pkg::W_SLOT'(live[$urandom_range(0, live.size() - 1)]);
		return tts_pkg::W_SLOT'($urandom_range(0, TABLE_DEPTH - 1));
	endfunction

	function automatic timer_req_t make_req(logic [tts_pkg::W_ACTION-1:0] action,
			logic [tts_pkg::W_TIME-1:0] now_ms, logic [tts_pkg::W_SLOT-1:0] slot,
			logic [tts_pkg::W_TIME-1:0] timeout_ms, bit periodic, bit notify);
		timer_req_t r;
		r.action = action;
		r.now_ms = now_ms;
		r.slot = slot;
		r.timeout_ms = timeout_ms;
		r.periodic = periodic;
		r.notify = notify;
		return r;
	endfunction

	// Random request on a running millisecond clock, with an occasional wild time.
	function automatic timer_req_t make_random_request();
		timer_req_t  r;
		int unsigned roll;
		int unsigned tmo_roll;
		r = make_req(tts_pkg::ACT_PROCESS, clock_ms,
			tts_pkg::W_SLOT'($urandom_range(0, TABLE_DEPTH - 1)), $urandom,
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		roll = $urandom_range(0, 99);
		if (roll < 34) begin
			clock_ms = clock_ms + $urandom_range(0, 30);
		end else if (roll < 60) begin
			r.action = tts_pkg::ACT_CREATE;
			clock_ms = clock_ms + $urandom_range(0, 4);
			tmo_roll = $urandom_range(0, 99);
			if (tmo_roll < 8)
				r.timeout_ms = '0;
			else if (tmo_roll >= 18)
				r.timeout_ms = $urandom_range(1, 60);
		end else if (roll < 72) begin
			r.action = tts_pkg::ACT_KILL;
			r.slot = pick_slot();
		end else if (roll < 82) begin
			r.action = tts_pkg::ACT_KILL_LATER;
			r.slot = pick_slot();
		end else if (roll < 96) begin
			r.action = tts_pkg::ACT_RESTART;
			clock_ms = clock_ms + $urandom_range(0, 10);
			r.slot = pick_slot();
		end else begin
			r.action = tts_pkg::W_ACTION'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
		end
		r.now_ms = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
		return r;
	endfunction

	// Offer one request word and wait for it to be taken.
	task automatic offer_request(input timer_req_t r);
		int unsigned gap;
		gap = send_gaps ? pick_gap() : 0;
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= r.action;
		req_if.now_ms <= r.now_ms;
		req_if.slot <= r.slot;
		req_if.timeout_ms <= r.timeout_ms;
		req_if.periodic <= r.periodic;
		req_if.notify <= r.notify;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		shadow.take_request(r);
	endtask

	// Result side: random stalls, and one long hold-off on request.
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				holds_done++;
			end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Check result words and track cycles without any handshake.
	always @(posedge clk) begin
		if (arst_n && ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && rsp_if.valid && rsp_if.ready)
			shadow.check_result({rsp_if.status, rsp_if.slot_out, rsp_if.last});
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("tb_timer_table_expiry_scan: FAIL");
		$finish;
	end

	// Stimulus: directed corner cases, then random phases with and without idling.
	initial begin
		int i;
		req_if.valid <= 1'b0;
		req_if.action <= tts_pkg::ACT_PROCESS;
		req_if.now_ms <= '0;
		req_if.slot <= '0;
		req_if.timeout_ms <= '0;
		req_if.periodic <= 1'b0;
		req_if.notify <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_gaps = 1'b1;
		recv_stalls = 1'b1;

		// Empty table: scan, kill and kill later on unused slots, and a bad action.
		offer_request(make_req(tts_pkg::ACT_PROCESS, '0, '0, '0, 1'b0, 1'b0));
		offer_request(make_req(tts_pkg::ACT_KILL, 32'd5, '0, '0, 1'b0, 1'b0));
		offer_request(make_req(tts_pkg::ACT_KILL_LATER, 32'd5, 4'd15, '1, 1'b1, 1'b1));
		offer_request(make_req(ACT_UNUSED_LAST, '1, 4'd15, '1, 1'b1, 1'b1));

		// Zero timeout across the wrap, maximum timeout, silent one-shot, wrapping periodic.
		offer_request(make_req(tts_pkg::ACT_CREATE, '1, '0, '0, 1'b1, 1'b1));
		offer_request(make_req(tts_pkg::ACT_CREATE, '0, '0, '1, 1'b0, 1'b1));
		offer_request(make_req(tts_pkg::ACT_CREATE, '0, '0, 32'd10, 1'b0, 1'b0));
		offer_request(make_req(tts_pkg::ACT_CREATE, 32'hFFFF_FFFE, '0, 32'd5, 1'b1, 1'b1));

		// Fill the rest of the table, then one create too many.
		for (i = 0; i < TABLE_DEPTH - 4; i++)
			offer_request(make_req(tts_pkg::ACT_CREATE, '0, '0, 32'd1000, i[0], i[1]));
		offer_request(make_req(tts_pkg::ACT_CREATE, 32'd7, '0, 32'd3, 1'b1, 1'b1));

		// Expiries, kill later, restart into the future, restart of a freed slot.
		offer_request(make_req(tts_pkg::ACT_PROCESS, 32'd20, '0, '0, 1'b0, 1'b0));
		offer_request(make_req(tts_pkg::ACT_KILL_LATER, 32'd21, 4'd3, '0, 1'b0, 1'b0));
		offer_request(make_req(tts_pkg::ACT_RESTART, 32'd100, 4'd1, '0, 1'b0, 1'b0));
		offer_request(make_req(tts_pkg::ACT_RESTART, 32'd22, 4'd2, '0, 1'b0, 1'b0));
		offer_request(make_req(tts_pkg::ACT_PROCESS, 32'd30, '0, '0, 1'b0, 1'b0));
		offer_request(make_req(tts_pkg::ACT_KILL, 32'd31, 4'd1, '0, 1'b0, 1'b0));

		clock_ms = 32'd40;
		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 0) begin
				send_gaps = 1'b0;
				recv_stalls = 1'b0;
			end else if (i == 100) begin
				send_gaps = 1'b1;
				recv_stalls = 1'b1;
			end else if (i == 200) begin
				// Keep offering back to back while the result side holds off.
				send_gaps = 1'b0;
				hold_request = 1'b1;
			end else if (i == 240) begin
				send_gaps = 1'b1;
			end else if (i == 300) begin
				// Move the running clock close to the 32-bit wrap.
				clock_ms = 32'hFFFF_FF00;
			end
			offer_request(make_random_request());
		end
		req_if.valid <= 1'b0;

		while (shadow.owed_results.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		shadow.faults += shadow.owed_results.size();

		$display("Covered %0d requests and %0d result words: %0d expiry events, %0d errors.",
			shadow.requests_taken, shadow.results_seen, shadow.expiries_seen,
			shadow.errors_seen);
		$display("Table-full rejections: %0d; long result hold-offs with requests pending: %0d.",
			shadow.full_rejects, holds_done);
		if (shadow.faults == 0)
			$display("tb_timer_table_expiry_scan: PASS");
		else
			$display("tb_timer_table_expiry_scan: FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/tts_pkg.sv
rtl/tts_in_if.sv
rtl/tts_out_if.sv
rtl/tts_dpath.sv
rtl/tts_ctrl.sv
rtl/timer_table_expiry_scan.sv
tb/tb_timer_table_expiry_scan.sv
